/* rtl/deadline_ordered_timer_queue_core_defines.svh */
// Assertion macros shared by the timer queue RTL.
`ifndef DEADLINE_ORDERED_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_ORDERED_TIMER_QUEUE_CORE_DEFINES_SVH

// Condition in the same cycle implies the check in the same cycle.
`define DOTQ_ASSERT_NOW(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error(msg);

// Condition in one cycle implies the check in the following cycle.
`define DOTQ_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

/* rtl/dotq_pkg.sv */
// Package with types and constants of the deadline ordered timer queue.
`timescale 1ns / 1ps
`default_nettype none
package dotq_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int DEADLINE_W   = 48;
    localparam int ID_W         = 32;

    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_ONESHOT  = 2'd1;
    localparam logic [1:0] MODE_PERIODIC = 2'd2;
    localparam logic [1:0] MODE_CANCEL   = 2'd3;

    localparam logic [2:0] KIND_ARMED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;

    typedef struct packed {
        logic [DEADLINE_W-1:0] deadline;
        logic [ID_W-1:0]       interval;
        logic [ID_W-1:0]       ident;
        logic                  periodic;
    } entry_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drop_match;
        logic drop_all;
    } cell_ctl_t;
endpackage
`default_nettype wire

/* rtl/deadline_ordered_timer_queue_core.sv */
// Top level of the deadline ordered timer queue: controller, re-arm buffer and cell chain.
//
//  Channel | Handshake              | Words
//  input   | in_valid / in_ready    | mode, duration_ms, cancel_id
//  output  | out_valid / out_ready  | kind, timer_id, last
//
// Arm and cancel pass through the execute state; a tick advances the clock, pops each expired
// timer from the head, then re-inserts each periodic one in the re-arm state.
// Every cell updates together, so one insert, removal or head pop moves the whole chain at once.
// Reset empties the chain and clears the clock and the id counter.
// A stalled output holds the controller; a new word is taken once the previous is done.
`timescale 1ns / 1ps
`default_nettype none
`include "deadline_ordered_timer_queue_core_defines.svh"
module deadline_ordered_timer_queue_core #(
    parameter int CAPACITY = dotq_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] duration_ms,
    input  wire logic [31:0] cancel_id,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       kind,
    output logic [31:0]      timer_id,
    output logic             last
);
    localparam int RES_IDX_W = $clog2(dotq_pkg::MAX_RESULTS);
    localparam int RES_CNT_W = RES_IDX_W + 1;
    localparam logic [RES_CNT_W-1:0] RES_MAX = RES_CNT_W'(dotq_pkg::MAX_RESULTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_POP   = 2'd2;
    localparam logic [1:0] ST_REARM = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  cmd_mode_reg, cmd_mode_next;
    logic [31:0] cmd_dur_reg, cmd_dur_next;
    logic [31:0] cmd_cid_reg, cmd_cid_next;
    logic [dotq_pkg::DEADLINE_W-1:0] now_reg, now_next;
    logic [31:0] next_id_reg, next_id_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic [RES_CNT_W-1:0] wr_cnt_reg, wr_cnt_next;
    logic [RES_CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    dotq_pkg::entry_t     fifo_reg [dotq_pkg::MAX_RESULTS];
    dotq_pkg::entry_t     fifo_rd_reg;
    logic                 fifo_push;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] timer_id_reg, timer_id_next;
    logic        last_reg, last_next;

    dotq_pkg::cell_ctl_t ctl;
    dotq_pkg::entry_t    new_entry;
    dotq_pkg::entry_t    cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_valid, cell_lt, cell_seen;
    logic out_free, head_due, second_due, full;

    assign out_free   = !out_valid_reg || out_ready;
    assign head_due   = cell_valid[0] && (cell_entry[0].deadline <= now_reg);
    assign second_due = cell_valid[1] && (cell_entry[1].deadline <= now_reg);
    assign full       = cell_valid[CAPACITY-1];
    assign in_ready   = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd_mode_next  = cmd_mode_reg;
        cmd_dur_next   = cmd_dur_reg;
        cmd_cid_next   = cmd_cid_reg;
        now_next       = now_reg;
        next_id_next   = next_id_reg;
        n_next         = n_reg;
        wr_cnt_next    = wr_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        fifo_push      = 1'b0;
        ctl            = '0;
        new_entry      = fifo_rd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        timer_id_next  = timer_id_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_mode_next = mode;
                    cmd_dur_next  = duration_ms;
                    cmd_cid_next  = cancel_id;
                    n_next        = '0;
                    wr_cnt_next   = '0;
                    rd_cnt_next   = '0;
                    if (mode == dotq_pkg::MODE_TICK)
                    begin
                        now_next   = now_reg + 1'b1;
                        state_next = ST_POP;
                    end
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                new_entry.deadline = now_reg + {16'd0, cmd_dur_reg};
                new_entry.interval = cmd_dur_reg;
                new_entry.ident    = next_id_reg;
                new_entry.periodic = (cmd_mode_reg == dotq_pkg::MODE_PERIODIC);
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                    if (cmd_mode_reg == dotq_pkg::MODE_CANCEL)
                    begin
                        ctl.drop_match = 1'b1;
                        timer_id_next  = cmd_cid_reg;
                        kind_next      = cell_seen[CAPACITY-1] ? dotq_pkg::KIND_CANCELLED
                                                               : dotq_pkg::KIND_UNKNOWN;
                    end
                    else if (full)
                    begin
                        kind_next     = dotq_pkg::KIND_FULL;
                        timer_id_next = '0;
                    end
                    else
                    begin
                        ctl.insert    = 1'b1;
                        kind_next     = dotq_pkg::KIND_ARMED;
                        timer_id_next = next_id_reg;
                        next_id_next  = next_id_reg + 1'b1;
                    end
                end
            end
            ST_POP:
            begin
                if (head_due && (n_reg < RES_MAX))
                begin
                    if (out_free)
                    begin
                        ctl.drop_all   = 1'b1;
                        out_valid_next = 1'b1;
                        kind_next      = dotq_pkg::KIND_EXPIRED;
                        timer_id_next  = cell_entry[0].ident;
                        last_next      = !(second_due && ((n_reg + 1'b1) < RES_MAX));
                        n_next         = n_reg + 1'b1;
                        if (cell_entry[0].periodic)
                        begin
                            fifo_push   = 1'b1;
                            wr_cnt_next = wr_cnt_reg + 1'b1;
                        end
                    end
                end
                else
                    state_next = ST_REARM;
            end
            ST_REARM:
            begin
                // Periodic timers go back in expiry order at the new time plus interval.
                if (rd_cnt_reg == wr_cnt_reg)
                    state_next = ST_IDLE;
                else
                begin
                    new_entry.deadline = now_reg + {16'd0, new_entry.interval};
                    ctl.insert         = 1'b1;
                    rd_cnt_next        = rd_cnt_reg + 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            next_id_reg   <= '0;
            n_reg         <= '0;
            wr_cnt_reg    <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            next_id_reg   <= next_id_next;
            n_reg         <= n_next;
            wr_cnt_reg    <= wr_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The buffer is never written on the cycle before the re-arm pass starts,
    // so the registered read already holds the first entry there.
    always_ff @(posedge clk)
    begin
        cmd_mode_reg <= cmd_mode_next;
        cmd_dur_reg  <= cmd_dur_next;
        cmd_cid_reg  <= cmd_cid_next;
        kind_reg     <= kind_next;
        timer_id_reg <= timer_id_next;
        last_reg     <= last_next;
        if (fifo_push)
            fifo_reg[wr_cnt_reg[RES_IDX_W-1:0]] <= cell_entry[0];
        fifo_rd_reg <= fifo_reg[rd_cnt_next[RES_IDX_W-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign timer_id  = timer_id_reg;
    assign last      = last_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        dotq_pkg::entry_t left_e, right_e;
        logic left_v, left_l, right_v, seen_i;
        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_v = 1'b1;
            assign left_l = 1'b1;
            assign seen_i = 1'b0;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_v = cell_valid[i-1];
            assign left_l = cell_lt[i-1];
            assign seen_i = cell_seen[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_e = cell_entry[i];
            assign right_v = 1'b0;
        end
        else
        begin : g_mid
            assign right_e = cell_entry[i+1];
            assign right_v = cell_valid[i+1];
        end
        dotq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .cancel_id   (cmd_cid_reg),
            .left_entry  (left_e),
            .left_valid  (left_v),
            .left_lt     (left_l),
            .right_entry (right_e),
            .right_valid (right_v),
            .seen_in     (seen_i),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .lt          (cell_lt[i]),
            .seen_out    (cell_seen[i])
        );
    end

    `DOTQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `DOTQ_ASSERT_NOW(a_valid_prefix, 1'b1, ((cell_valid + 1'b1) & cell_valid) == '0, "chain gap")
    `DOTQ_ASSERT_NOW(a_fifo_bound, 1'b1, wr_cnt_reg <= RES_MAX && rd_cnt_reg <= wr_cnt_reg, "rearm count")
    `DOTQ_ASSERT_NOW(a_idle_drained, state_reg == ST_IDLE && !in_valid, rd_cnt_reg == wr_cnt_reg, "rearm left")
endmodule
`default_nettype wire

/* rtl/dotq_cell.sv */
// One cell of the sorted timer chain: holds one entry and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module dotq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dotq_pkg::cell_ctl_t ctl,
    input  wire dotq_pkg::entry_t   new_entry,
    input  wire logic [31:0]        cancel_id,
    input  wire dotq_pkg::entry_t   left_entry,
    input  wire logic               left_valid,
    input  wire logic               left_lt,
    input  wire dotq_pkg::entry_t   right_entry,
    input  wire logic               right_valid,
    input  wire logic               seen_in,
    output dotq_pkg::entry_t        entry,
    output logic                    valid,
    output logic                    lt,
    output logic                    seen_out
);
    dotq_pkg::entry_t entry_reg, entry_next;
    logic             valid_reg, valid_next;
    logic             match;

    assign lt       = valid_reg && (entry_reg.deadline < new_entry.deadline);
    assign match    = valid_reg && (entry_reg.ident == cancel_id);
    assign seen_out = seen_in || match;
    assign entry    = entry_reg;
    assign valid    = valid_reg;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (ctl.insert)
        begin
            // Entries at or after the insert point move one place toward the tail.
            if (!lt)
            begin
                if (left_lt)
                begin
                    entry_next = new_entry;
                    valid_next = 1'b1;
                end
                else
                begin
                    entry_next = left_entry;
                    valid_next = left_valid;
                end
            end
        end
        else if (ctl.drop_all || (ctl.drop_match && seen_out))
        begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end
endmodule
`default_nettype wire
